>>> rtl/sma_pkg.sv
// Shared types and codes for the stack machine arithmetic unit.
// No dependencies; imported by the channel interfaces and all rtl modules.
`timescale 1ns / 1ps
`default_nettype none

package sma_pkg;

   typedef logic [2:0]        opcode_type;
   typedef logic [1:0]        status_type;
   typedef logic [31:0]       word_type;
   typedef logic signed [31:0] sword_type;
   typedef logic [6:0]        count_out_type;

   // opcodes
   localparam opcode_type OP_PUSH = 3'd0;
   localparam opcode_type OP_ADD  = 3'd1;
   localparam opcode_type OP_SUB  = 3'd2;
   localparam opcode_type OP_MUL  = 3'd3;
   localparam opcode_type OP_DIV  = 3'd4;
   localparam opcode_type OP_MOD  = 3'd5;

   // status codes
   localparam status_type ST_OK      = 2'd0;
   localparam status_type ST_SHORT   = 2'd1;
   localparam status_type ST_DIVZERO = 2'd2;
   localparam status_type ST_FULL    = 2'd3;

   // control from the sequencer to the divider
   typedef struct packed {
      logic start;
      logic want_rem;
   } div_ctl_type;

endpackage

`default_nettype wire

>>> rtl/sma_req_if.sv
// Request channel of the stack machine: opcode and push value.
// Depends on sma_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface sma_req_if;
   import sma_pkg::*;

   logic       valid;
   logic       ready;
   opcode_type opcode;
   sword_type  push_value;

   modport source (output valid, output opcode, output push_value, input ready);
   modport sink   (input valid, input opcode, input push_value, output ready);
endinterface

`default_nettype wire

>>> rtl/sma_rsp_if.sv
// Response channel of the stack machine: top value, count and status.
// Depends on sma_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface sma_rsp_if;
   import sma_pkg::*;

   logic          valid;
   logic          ready;
   sword_type     top_value;
   count_out_type stack_count;
   status_type    status;

   modport source (output valid, output top_value, output stack_count, output status,
                   input ready);
   modport sink   (input valid, input top_value, input stack_count, input status,
                   output ready);
endinterface

`default_nettype wire

>>> rtl/stack_machine_alu.sv
// Top level of the stack machine arithmetic unit: sequencer, stack memory, output register.
// Depends on sma_pkg, sma_req_if, sma_rsp_if and sma_div.
`timescale 1ns / 1ps
`default_nettype none

// A bounded stack of STACK_DEPTH signed 32-bit words with push, add, sub, mul, div and
// mod. Each request item gives exactly one response item carrying the top of stack (0 when
// empty), the entry count modulo 128 and a status code; on any error the stack is left
// unchanged. One item is in work at a time. Push, add, sub, mul, the unused opcodes and
// every error case pass through an execute and a finish state after acceptance; div and
// mod wait between the two for the radix-2 divider, which retires one quotient bit per
// cycle. The entries lie in a single-port-read synchronous memory with the top of stack
// held in a register, so each arithmetic item reads the second entry once at acceptance
// and writes back at most once at completion. A response waiting in the output register
// does not block acceptance; only the completion of the following item waits for it.
module stack_machine_alu #(
   parameter int STACK_DEPTH = 64
) (
   input wire         clock,
   input wire         reset,
   sma_req_if.sink    req_channel,
   sma_rsp_if.source  rsp_channel
);
   import sma_pkg::*;

   localparam int ADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int CNT_W  = $clog2(STACK_DEPTH + 1);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_EXEC   = 2'd1;
   localparam logic [1:0] S_DIV    = 2'd2;
   localparam logic [1:0] S_FINISH = 2'd3;

   // sequencer and stack state
   logic [1:0]       state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   word_type         top_ff, top_in;
   opcode_type       op_ff, op_in;
   word_type         pv_ff, pv_in;
   word_type         result_ff, result_in;
   status_type       status_ff, status_in;
   logic             push_ff, push_in;
   logic             pop_ff, pop_in;

   // output register
   logic             rsp_valid_ff, rsp_valid_in;
   word_type         rsp_top_ff, rsp_top_in;
   count_out_type    rsp_count_ff, rsp_count_in;
   status_type       rsp_status_ff, rsp_status_in;

   // stack memory
   word_type         mem [STACK_DEPTH];
   word_type         rd_data_ff;
   logic             rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic             wr_en;
   logic [ADDR_W-1:0] wr_addr;
   word_type         wr_data;

   logic             accept;
   logic             slot_free;
   logic [CNT_W-1:0] count_m2;
   logic [CNT_W+6:0] count_ext;
   word_type         op_a;
   word_type         op_b;

   div_ctl_type      div_ctl;
   logic             div_done;
   word_type         div_result;

   assign accept    = req_channel.valid && req_channel.ready;
   assign slot_free = !rsp_valid_ff || rsp_channel.ready;
   assign count_m2  = count_ff - CNT_W'(2);
   assign op_a      = top_ff;
   assign op_b      = rd_data_ff;

   // the second entry is fetched while the item is taken in
   assign rd_en   = accept;
   assign rd_addr = count_m2[ADDR_W-1:0];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   sma_div u_div (
      .clock    (clock),
      .reset    (reset),
      .ctl      (div_ctl),
      .dividend (op_b),
      .divisor  (op_a),
      .done     (div_done),
      .result   (div_result)
   );

   // sequencer
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      top_in        = top_ff;
      op_in         = op_ff;
      pv_in         = pv_ff;
      result_in     = result_ff;
      status_in     = status_ff;
      push_in       = push_ff;
      pop_in        = pop_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_channel.ready;
      rsp_top_in    = rsp_top_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_status_in = rsp_status_ff;
      div_ctl       = '0;
      wr_en         = 1'b0;
      wr_addr       = count_ff[ADDR_W-1:0];
      wr_data       = pv_ff;
      count_ext     = '0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in    = req_channel.opcode;
               pv_in    = word_type'(req_channel.push_value);
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            status_in = ST_OK;
            push_in   = 1'b0;
            pop_in    = 1'b0;
            state_in  = S_FINISH;
            case (op_ff)
               OP_PUSH: begin
                  if (count_ff >= CNT_W'(STACK_DEPTH)) begin
                     status_in = ST_FULL;
                  end else begin
                     push_in = 1'b1;
                  end
               end
               OP_ADD, OP_SUB, OP_MUL: begin
                  if (count_ff < CNT_W'(2)) begin
                     status_in = ST_SHORT;
                  end else begin
                     pop_in = 1'b1;
                     if (op_ff == OP_ADD) begin
                        result_in = op_b + op_a;
                     end else if (op_ff == OP_SUB) begin
                        result_in = op_b - op_a;
                     end else begin
                        result_in = op_b * op_a;
                     end
                  end
               end
               OP_DIV, OP_MOD: begin
                  if (count_ff < CNT_W'(2)) begin
                     status_in = ST_SHORT;
                  end else if (op_a == '0) begin
                     status_in = ST_DIVZERO;
                  end else begin
                     div_ctl.start    = 1'b1;
                     div_ctl.want_rem = (op_ff == OP_MOD);
                     state_in         = S_DIV;
                  end
               end
               default: begin
                  // unused opcodes leave the stack alone
               end
            endcase
         end
         S_DIV: begin
            if (div_done) begin
               result_in = div_result;
               pop_in    = 1'b1;
               state_in  = S_FINISH;
            end
         end
         S_FINISH: begin
            // commit the stack and load the response together
            if (slot_free) begin
               if (push_ff) begin
                  wr_en    = 1'b1;
                  wr_addr  = count_ff[ADDR_W-1:0];
                  wr_data  = pv_ff;
                  top_in   = pv_ff;
                  count_in = count_ff + CNT_W'(1);
               end else if (pop_ff) begin
                  wr_en    = 1'b1;
                  wr_addr  = count_m2[ADDR_W-1:0];
                  wr_data  = result_ff;
                  top_in   = result_ff;
                  count_in = count_ff - CNT_W'(1);
               end
               count_ext     = {7'd0, count_in};
               rsp_valid_in  = 1'b1;
               rsp_top_in    = (count_in == '0) ? '0 : top_in;
               rsp_count_in  = count_ext[6:0];
               rsp_status_in = status_ff;
               push_in       = 1'b0;
               pop_in        = 1'b0;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         push_ff      <= 1'b0;
         pop_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         push_ff      <= push_in;
         pop_ff       <= pop_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      top_ff        <= top_in;
      op_ff         <= op_in;
      pv_ff         <= pv_in;
      result_ff     <= result_in;
      status_ff     <= status_in;
      rsp_top_ff    <= rsp_top_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_status_ff <= rsp_status_in;
   end

   // channel outputs
   assign req_channel.ready       = (state_ff == S_IDLE);
   assign rsp_channel.valid       = rsp_valid_ff;
   assign rsp_channel.top_value   = sword_type'(rsp_top_ff);
   assign rsp_channel.stack_count = rsp_count_ff;
   assign rsp_channel.status      = rsp_status_ff;

`ifndef SYNTHESIS
   // the count never passes the depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(STACK_DEPTH))
      else $error("stack count beyond depth");

   // divider results arrive only while the sequencer waits for them
   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == S_DIV)
      else $error("divider done outside divide wait");

   // a failed item never commits a stack change
   a_error_no_commit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FINISH && status_ff != ST_OK) |-> !(push_ff || pop_ff))
      else $error("stack change on error status");

   // completion moves the count by at most one
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FINISH && slot_free) |=>
         (count_ff == $past(count_ff) + CNT_W'(1) || count_ff == $past(count_ff) ||
          count_ff == $past(count_ff) - CNT_W'(1)))
      else $error("stack count jumped");
`endif

endmodule

`default_nettype wire

>>> rtl/sma_div.sv
// Radix-2 restoring signed divider, one quotient bit per cycle.
// Depends on sma_pkg; returns truncated quotient or dividend-signed remainder.
`timescale 1ns / 1ps
`default_nettype none

module sma_div (
   input  wire                       clock,
   input  wire                       reset,
   input  wire sma_pkg::div_ctl_type ctl,
   input  wire sma_pkg::word_type    dividend,
   input  wire sma_pkg::word_type    divisor,
   output logic                      done,
   output sma_pkg::word_type         result
);
   import sma_pkg::*;

   localparam logic [1:0] D_IDLE = 2'd0;
   localparam logic [1:0] D_RUN  = 2'd1;
   localparam logic [1:0] D_FIX  = 2'd2;

   logic [1:0] state_ff, state_in;
   logic [4:0] step_ff, step_in;
   word_type   rem_ff, rem_in;
   word_type   quo_ff, quo_in;
   word_type   den_ff, den_in;
   logic       neg_q_ff, neg_q_in;
   logic       neg_r_ff, neg_r_in;
   logic       mod_ff, mod_in;
   word_type   res_ff, res_in;
   logic       done_ff, done_in;

   logic [32:0] shifted;
   logic [32:0] diff;

   // one restoring step
   assign shifted = {rem_ff, quo_ff[31]};
   assign diff    = shifted - {1'b0, den_ff};

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      den_in   = den_ff;
      neg_q_in = neg_q_ff;
      neg_r_in = neg_r_ff;
      mod_in   = mod_ff;
      res_in   = res_ff;
      done_in  = 1'b0;
      case (state_ff)
         D_IDLE: begin
            if (ctl.start) begin
               // load magnitudes and remember the signs
               quo_in   = dividend[31] ? (32'd0 - dividend) : dividend;
               den_in   = divisor[31] ? (32'd0 - divisor) : divisor;
               rem_in   = '0;
               neg_q_in = dividend[31] ^ divisor[31];
               neg_r_in = dividend[31];
               mod_in   = ctl.want_rem;
               step_in  = '0;
               state_in = D_RUN;
            end
         end
         D_RUN: begin
            if (!diff[32]) begin
               rem_in = diff[31:0];
               quo_in = {quo_ff[30:0], 1'b1};
            end else begin
               rem_in = shifted[31:0];
               quo_in = {quo_ff[30:0], 1'b0};
            end
            step_in = step_ff + 5'd1;
            if (step_ff == 5'd31) begin
               state_in = D_FIX;
            end
         end
         D_FIX: begin
            // sign correction, wraps for most negative over minus one
            if (mod_ff) begin
               res_in = neg_r_ff ? (32'd0 - rem_ff) : rem_ff;
            end else begin
               res_in = neg_q_ff ? (32'd0 - quo_ff) : quo_ff;
            end
            done_in  = 1'b1;
            state_in = D_IDLE;
         end
         default: begin
            state_in = D_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= D_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      step_ff  <= step_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      den_ff   <= den_in;
      neg_q_ff <= neg_q_in;
      neg_r_ff <= neg_r_in;
      mod_ff   <= mod_in;
      res_ff   <= res_in;
   end

   assign done   = done_ff;
   assign result = res_ff;

`ifndef SYNTHESIS
   // a start is only honored when idle
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      (ctl.start && state_ff == D_IDLE) |=> state_ff == D_RUN)
      else $error("divider did not start");

   // the run phase always ends in the fix phase
   a_run_to_fix: assert property (@(posedge clock) disable iff (reset)
      (state_ff == D_RUN && step_ff == 5'd31) |=> state_ff == D_FIX)
      else $error("divider run did not end");

   // done follows the fix phase and nothing else
   a_done_fix: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(state_ff) == D_FIX)
      else $error("divider done without fix phase");
`endif

endmodule

`default_nettype wire

>>> tb/tb.sv
// Self-checking testbench for stack_machine_alu: directed table, then random stack traffic.
// Depends on sma_pkg, sma_req_if, sma_rsp_if and the stack_machine_alu rtl.
`timescale 1ns / 1ps

module tb;
   import sma_pkg::*;

   localparam int STACK_DEPTH = 64;
   localparam int QUIET_LIMIT = 2000;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int DRAIN_CYCLES = 50;

   localparam opcode_type OP_NOP6 = 3'd6;
   localparam opcode_type OP_NOP7 = 3'd7;
   localparam sword_type INT_MIN_V = 32'sh8000_0000;
   localparam sword_type INT_MAX_V = 32'sh7fff_ffff;

   typedef struct packed {
      sword_type     top_value;
      count_out_type stack_count;
      status_type    status;
   } stack_view_type;

   typedef struct packed {
      opcode_type     op;
      sword_type      value;
      logic           typed;
      stack_view_type view;
   } dir_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   sma_req_if req_ch ();
   sma_rsp_if rsp_ch ();

   stack_machine_alu #(.STACK_DEPTH(STACK_DEPTH)) u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_channel (req_ch),
      .rsp_channel (rsp_ch)
   );

   // clock, 10 ns period
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // directed table: each row's view is typed in, or predicted by the shadow stack where typed is clear
   dir_row_type directed_rows [25] = '{
      '{OP_ADD,  32'sd0,    1'b1, '{32'sd0,    7'd0, ST_SHORT}},
      '{OP_DIV,  32'sd0,    1'b1, '{32'sd0,    7'd0, ST_SHORT}},
      '{OP_NOP6, INT_MAX_V, 1'b1, '{32'sd0,    7'd0, ST_OK}},
      '{OP_PUSH, INT_MAX_V, 1'b1, '{INT_MAX_V, 7'd1, ST_OK}},
      '{OP_MOD,  32'sd0,    1'b1, '{INT_MAX_V, 7'd1, ST_SHORT}},
      '{OP_PUSH, 32'sd1,    1'b1, '{32'sd1,    7'd2, ST_OK}},
      '{OP_ADD,  32'sd0,    1'b1, '{INT_MIN_V, 7'd1, ST_OK}},
      '{OP_PUSH, -32'sd1,   1'b1, '{-32'sd1,   7'd2, ST_OK}},
      '{OP_DIV,  32'sd0,    1'b1, '{INT_MIN_V, 7'd1, ST_OK}},
      '{OP_PUSH, -32'sd1,   1'b1, '{-32'sd1,   7'd2, ST_OK}},
      '{OP_MOD,  32'sd0,    1'b1, '{32'sd0,    7'd1, ST_OK}},
      '{OP_PUSH, 32'sd0,    1'b1, '{32'sd0,    7'd2, ST_OK}},
      '{OP_DIV,  -32'sd1,   1'b1, '{32'sd0,    7'd2, ST_DIVZERO}},
      '{OP_MOD,  32'sd0,    1'b1, '{32'sd0,    7'd2, ST_DIVZERO}},
      '{OP_NOP7, -32'sd1,   1'b1, '{32'sd0,    7'd2, ST_OK}},
      '{OP_PUSH, 32'sd7,    1'b1, '{32'sd7,    7'd3, ST_OK}},
      '{OP_PUSH, -32'sd2,   1'b1, '{-32'sd2,   7'd4, ST_OK}},
      '{OP_DIV,  32'sd0,    1'b0, '{32'sd0,    7'd0, ST_OK}},
      '{OP_PUSH, -32'sd7,   1'b1, '{-32'sd7,   7'd4, ST_OK}},
      '{OP_PUSH, 32'sd2,    1'b1, '{32'sd2,    7'd5, ST_OK}},
      '{OP_MOD,  32'sd0,    1'b0, '{32'sd0,    7'd0, ST_OK}},
      '{OP_MUL,  32'sd0,    1'b0, '{32'sd0,    7'd0, ST_OK}},
      '{OP_PUSH, INT_MIN_V, 1'b1, '{INT_MIN_V, 7'd4, ST_OK}},
      '{OP_MUL,  32'sd0,    1'b0, '{32'sd0,    7'd0, ST_OK}},
      '{OP_SUB,  32'sd0,    1'b1, '{INT_MIN_V, 7'd2, ST_OK}}
   };

   // random phases: length and share of pushes, so the stack fills and drains
   int phase_len  [5] = '{110, 110, 60, 110, 110};
   int phase_push [5] = '{85, 15, 50, 85, 15};

   // shadow stack
   word_type stack_mem [STACK_DEPTH];
   int       entry_cnt = 0;

   stack_view_type pending_views [$];
   logic           row_typed;
   stack_view_type row_view;

   int  fail_count = 0;
   int  quiet_cycles = 0;
   int  burst_left = 1;
   int  op_seen [8];
   int  status_seen [4];
   int  peak_count = 0;
   bit  hold_off_go = 1'b0;
   bit  hold_active = 1'b0;

   wire req_fire = req_ch.valid && req_ch.ready;
   wire rsp_fire = rsp_ch.valid && rsp_ch.ready;

   // one step of the stack: updates the shadow state, returns the view after it
   function automatic stack_view_type apply_op(opcode_type op, word_type value);
      stack_view_type view;
      word_type       a;
      word_type       b;
      word_type       r;
      longint         sa;
      longint         sb;
      bit             done_ok;
      view = '0;
      view.status = ST_OK;
      if (op == OP_PUSH) begin
         if (entry_cnt >= STACK_DEPTH) begin
            view.status = ST_FULL;
         end else begin
            stack_mem[entry_cnt] = value;
            entry_cnt++;
         end
      end else if (op <= OP_MOD) begin
         if (entry_cnt < 2) begin
            view.status = ST_SHORT;
         end else begin
            a = stack_mem[entry_cnt - 1];
            b = stack_mem[entry_cnt - 2];
            sa = $signed(a);
            sb = $signed(b);
            r = '0;
            done_ok = 1'b1;
            case (op)
               OP_ADD: r = b + a;
               OP_SUB: r = b - a;
               OP_MUL: r = b * a;
               default: begin
                  if (a == '0) begin
                     done_ok = 1'b0;
                     view.status = ST_DIVZERO;
                  end else if (op == OP_DIV) begin
                     r = word_type'(sb / sa);
                  end else begin
                     r = word_type'(sb % sa);
                  end
               end
            endcase
            if (done_ok) begin
               entry_cnt--;
               stack_mem[entry_cnt - 1] = r;
            end
         end
      end
      view.top_value = (entry_cnt > 0) ? stack_mem[entry_cnt - 1] : '0;
      view.stack_count = count_out_type'(entry_cnt);
      return view;
   endfunction

   // push values biased toward zero, ones and the extremes
   function automatic sword_type pick_value();
      case ($urandom_range(0, 9))
         0: return 32'sd0;
         1: return 32'sd1;
         2: return -32'sd1;
         3: return INT_MIN_V;
         4: return INT_MAX_V;
         5, 6: return sword_type'($urandom_range(0, 40)) - 32'sd20;
         default: return sword_type'($urandom);
      endcase
   endfunction

   // offer one item and wait for it to be taken; gaps fall between bursts
   task automatic offer(opcode_type op, sword_type value, logic typed, stack_view_type view);
      int gap;
      req_ch.valid <= 1'b1;
      req_ch.opcode <= op;
      req_ch.push_value <= value;
      row_typed <= typed;
      row_view <= view;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = $urandom_range(1, 16);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (!hold_active && gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // checker: responses first, since a response never belongs to a same-edge request
   always @(posedge clock) begin
      stack_view_type want;
      stack_view_type predicted;
      if (!reset) begin
         if (rsp_fire) begin
            if (pending_views.size() == 0) begin
               $error("response item with no request outstanding");
               fail_count++;
            end else begin
               want = pending_views.pop_front();
               if (rsp_ch.top_value !== want.top_value) begin
                  $error("top_value: expected %0d, got %0d", want.top_value, rsp_ch.top_value);
                  fail_count++;
               end
               if (rsp_ch.stack_count !== want.stack_count) begin
                  $error("stack_count: expected %0d, got %0d",
                         want.stack_count, rsp_ch.stack_count);
                  fail_count++;
               end
               if (rsp_ch.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
                  fail_count++;
               end
            end
         end
         if (req_fire) begin
            predicted = apply_op(req_ch.opcode, req_ch.push_value);
            pending_views.push_back(row_typed ? row_view : predicted);
            op_seen[req_ch.opcode]++;
            status_seen[predicted.status]++;
            if (entry_cnt > peak_count) peak_count = entry_cnt;
         end
      end
   end

   // watchdog on cycles with no item moving
   always @(posedge clock) begin
      if (!reset) begin
         if (req_fire || rsp_fire) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAIL");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   // receiver: segments of always ready, coin flip and heavy stall, plus one long hold-off
   initial begin
      int mode;
      int seg;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_off_go && !hold_active) begin
            hold_active = 1'b1;
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            hold_off_go = 1'b0;
            hold_active = 1'b0;
         end
         mode = $urandom_range(0, 2);
         seg = $urandom_range(20, 150);
         repeat (seg) begin
            case (mode)
               0: rsp_ch.ready <= 1'b1;
               1: rsp_ch.ready <= 1'($urandom_range(0, 1));
               default: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
            endcase
            @(posedge clock);
         end
      end
   end

   // stimulus and end of run
   initial begin
      int         push_pct;
      int         r;
      opcode_type op;
      req_ch.valid <= 1'b0;
      req_ch.opcode <= OP_PUSH;
      req_ch.push_value <= '0;
      row_typed <= 1'b0;
      row_view <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         offer(directed_rows[i].op, directed_rows[i].value,
               directed_rows[i].typed, directed_rows[i].view);
      end

      for (int p = 0; p < 5; p++) begin
         if (p == 2) hold_off_go = 1'b1;
         push_pct = phase_push[p];
         repeat (phase_len[p]) begin
            r = $urandom_range(0, 99);
            if (r < push_pct) begin
               op = OP_PUSH;
            end else if ($urandom_range(0, 19) == 0) begin
               op = ($urandom_range(0, 1) == 0) ? OP_NOP6 : OP_NOP7;
            end else begin
               op = opcode_type'($urandom_range(OP_ADD, OP_MOD));
            end
            offer(op, pick_value(), 1'b0, '0);
         end
      end
      req_ch.valid <= 1'b0;

      while (pending_views.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("run covered push %0d, add %0d, sub %0d, mul %0d, div %0d, mod %0d, nop %0d",
               op_seen[OP_PUSH], op_seen[OP_ADD], op_seen[OP_SUB], op_seen[OP_MUL],
               op_seen[OP_DIV], op_seen[OP_MOD], op_seen[OP_NOP6] + op_seen[OP_NOP7]);
      $display("outcomes ok %0d, too short %0d, div by zero %0d, full %0d; deepest stack %0d",
               status_seen[ST_OK], status_seen[ST_SHORT], status_seen[ST_DIVZERO],
               status_seen[ST_FULL], peak_count);
      if (fail_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
